// File: design/ifdc_pkg.sv
// Package for the IMU frame decoder and calibrator.
// Holds the shared types, register indexes, mode and status codes.
// No dependencies.
package ifdc_pkg;

  // Frame store size and frame lengths in bytes.
  localparam int unsigned FRAME_BYTES = 20;
  localparam logic [4:0] LEN_REG   = 5'd12;
  localparam logic [4:0] LEN_FIFO  = 5'd16;
  localparam logic [4:0] LEN_HIRES = 5'd20;

  // Frame mode codes.
  localparam logic [1:0] MODE_REG   = 2'd0;
  localparam logic [1:0] MODE_FIFO  = 2'd1;
  localparam logic [1:0] MODE_HIRES = 2'd2;

  // Frame status codes.
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_ALL_ONES = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // Register indexes (byte address divided by eight).
  localparam logic [2:0] REG_FRAME_MODE    = 3'd0;
  localparam logic [2:0] REG_ACCEL_RANGE   = 3'd1;
  localparam logic [2:0] REG_GYRO_RANGE    = 3'd2;
  localparam logic [2:0] REG_ACCEL_OFFSETS = 3'd3;
  localparam logic [2:0] REG_GYRO_OFFSETS  = 3'd4;
  localparam logic [2:0] REG_ACCEL_GAINS   = 3'd5;

  localparam logic [47:0] GAINS_RESET = 48'h4000_4000_4000;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]  frame_mode;
    logic [1:0]  accel_range;
    logic [2:0]  gyro_range;
    logic [62:0] accel_offsets;
    logic [62:0] gyro_offsets;
    logic [47:0] accel_gains;
  } cfg_t;

  // One completed frame, unpacked: accel x,y,z then gyro x,y,z, 20-bit signed.
  typedef struct packed {
    logic [5:0][19:0] raw;
    logic [1:0]       status;
  } frame_t;

endpackage

// File: design/ifdc_regs.sv
// APB configuration registers for the IMU frame decoder.
// Depends on ifdc_pkg for register indexes and the configuration struct.
module ifdc_regs
  import ifdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes, masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_mode    <= MODE_REG;
      cfg.accel_range   <= 2'd0;
      cfg.gyro_range    <= 3'd0;
      cfg.accel_offsets <= '0;
      cfg.gyro_offsets  <= '0;
      cfg.accel_gains   <= GAINS_RESET;
    end else if (wr_en) begin
      unique case (index)
        REG_FRAME_MODE:    cfg.frame_mode    <= pwdata[1:0];
        REG_ACCEL_RANGE:   cfg.accel_range   <= pwdata[1:0];
        REG_GYRO_RANGE:    cfg.gyro_range    <= pwdata[2:0];
        REG_ACCEL_OFFSETS: cfg.accel_offsets <= pwdata[62:0];
        REG_GYRO_OFFSETS:  cfg.gyro_offsets  <= pwdata[62:0];
        REG_ACCEL_GAINS:   cfg.accel_gains   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read data decode.
  always_comb begin
    unique case (index)
      REG_FRAME_MODE:    prdata = {62'd0, cfg.frame_mode};
      REG_ACCEL_RANGE:   prdata = {62'd0, cfg.accel_range};
      REG_GYRO_RANGE:    prdata = {61'd0, cfg.gyro_range};
      REG_ACCEL_OFFSETS: prdata = {1'b0, cfg.accel_offsets};
      REG_GYRO_OFFSETS:  prdata = {1'b0, cfg.gyro_offsets};
      REG_ACCEL_GAINS:   prdata = {16'd0, cfg.accel_gains};
      default:           prdata = '0;
    endcase
  end

endmodule

// File: design/ifdc_capture.sv
// Byte capture for the IMU frame decoder: byte position, frame store and unpacking.
// Depends on ifdc_pkg for frame codes and the frame struct.
module ifdc_capture
  import ifdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  cfg_t       cfg,
  output logic       frame_done,
  output frame_t     frame
);

  logic [4:0] position;
  logic [4:0] pos_eff;
  logic [4:0] frame_len;
  logic [5:0] pos_inc;
  logic [7:0] store [FRAME_BYTES];
  logic [7:0] b     [FRAME_BYTES];
  logic [4:0] base;
  logic [15:0] word [6];
  logic       all_ones;

  assign pos_eff = frame_start ? 5'd0 : position;
  assign pos_inc = {1'b0, pos_eff} + 6'd1;

  always_comb begin
    unique case (cfg.frame_mode)
      MODE_FIFO:  frame_len = LEN_FIFO;
      MODE_HIRES: frame_len = LEN_HIRES;
      default:    frame_len = LEN_REG;
    endcase
  end

  assign frame_done = accept && (pos_inc >= {1'b0, frame_len});

  // Byte position: back to zero at the end of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 5'd0;
    end else if (accept) begin
      if (pos_inc >= {1'b0, frame_len}) begin
        position <= 5'd0;
      end else begin
        position <= pos_inc[4:0];
      end
    end
  end

  // Frame store; entries are only read after they have been written in this frame.
  always_ff @(posedge clk) begin
    if (accept && (pos_eff < 5'(FRAME_BYTES))) begin
      store[pos_eff] <= data_byte;
    end
  end

  // Frame view with the incoming byte merged in.
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      b[i] = (pos_eff == 5'(i)) ? data_byte : store[i];
    end
  end

  // Big-endian 16-bit words from byte 0 or byte 1.
  assign base = (cfg.frame_mode == MODE_FIFO) ? 5'd1 : 5'd0;
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      word[k] = {b[base + 5'(2 * k)], b[base + 5'(2 * k + 1)]};
    end
  end

  assign all_ones = (word[0] == 16'hFFFF) && (word[1] == 16'hFFFF) &&
                    (word[2] == 16'hFFFF) && (word[3] == 16'hFFFF);

  // Unpack the six axes and set the status.
  always_comb begin
    frame.status = ST_VALID;
    if (cfg.frame_mode == MODE_HIRES) begin
      frame.raw[0] = {b[1],  b[2],  b[17][7:4]};
      frame.raw[1] = {b[3],  b[4],  b[18][7:4]};
      frame.raw[2] = {b[5],  b[6],  b[19][7:4]};
      frame.raw[3] = {b[7],  b[8],  b[17][3:0]};
      frame.raw[4] = {b[9],  b[10], b[18][3:0]};
      frame.raw[5] = {b[11], b[12], b[19][3:0]};
    end else begin
      for (int k = 0; k < 6; k++) begin
        frame.raw[k] = {{4{word[k][15]}}, word[k]};
      end
    end
    if ((cfg.frame_mode == MODE_FIFO) || (cfg.frame_mode == MODE_HIRES)) begin
      if (b[0][7]) begin
        frame.status = ST_EMPTY;
      end
    end else if (all_ones) begin
      frame.status = ST_ALL_ONES;
    end
  end

endmodule

// File: design/ifdc_calib.sv
// Calibration pipeline: range scaling, offset subtraction, gain, rounding and saturation.
// Depends on ifdc_pkg for the configuration and frame structs and status codes.
module ifdc_calib
  import ifdc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  input  frame_t       in_frame,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [143:0] out_data,
  output logic [1:0]   out_status
);

  // Stage registers.
  logic         v1, v2, v3;
  frame_t       s1;
  logic signed [22:0] adiff [3];
  logic signed [21:0] rate2 [3];
  logic [1:0]         st2;
  logic signed [39:0] prod  [3];
  logic signed [21:0] rate3 [3];
  logic [1:0]         st3;

  logic rdy1, rdy2, rdy3, rdy_o;
  logic [2:0] ash, gsh;

  // Next values of the stages.
  logic signed [22:0] adiff_next [3];
  logic signed [21:0] rate_next  [3];
  logic signed [39:0] prod_next  [3];
  logic [143:0]       data_next;

  assign rdy_o    = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy_o;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Valid bits of each stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy_o) out_valid <= v3;
    end
  end

  // Range shifts; none in high-resolution mode.
  always_comb begin
    if (cfg.frame_mode == MODE_HIRES) begin
      ash = 3'd0;
      gsh = 3'd0;
    end else begin
      ash = 3'd4 - {1'b0, cfg.accel_range};
      gsh = (cfg.gyro_range <= 3'd4) ? 3'd4 - cfg.gyro_range : 3'd0;
    end
  end

  // Stage one: scale and subtract offsets; the gyro difference is saturated here.
  always_comb begin
    logic signed [19:0] a_sc, g_sc;
    logic signed [20:0] a_off, g_off;
    logic signed [22:0] g_diff;
    for (int k = 0; k < 3; k++) begin
      a_sc  = $signed(s1.raw[k] << ash);
      g_sc  = $signed(s1.raw[k + 3] << gsh);
      a_off = $signed(cfg.accel_offsets[21 * k +: 21]);
      g_off = $signed(cfg.gyro_offsets[21 * k +: 21]);
      adiff_next[k] = 23'(a_sc) - 23'(a_off);
      g_diff        = 23'(g_sc) - 23'(g_off);
      if (g_diff > 23'sd2097151) begin
        rate_next[k] = 22'sd2097151;
      end else if (g_diff < -23'sd2097152) begin
        rate_next[k] = -22'sd2097152;
      end else begin
        rate_next[k] = g_diff[21:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1 <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      adiff <= adiff_next;
      rate2 <= rate_next;
      st2   <= s1.status;
    end
  end

  // Stage two: multiply by the Q2.14 gain.
  always_comb begin
    logic signed [16:0] gain;
    for (int k = 0; k < 3; k++) begin
      gain         = $signed({1'b0, cfg.accel_gains[16 * k +: 16]});
      prod_next[k] = 40'(adiff[k]) * 40'(gain);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      prod  <= prod_next;
      rate3 <= rate2;
      st3   <= st2;
    end
  end

  // Stage three: round to nearest, saturate, clear data of flagged frames.
  always_comb begin
    logic signed [39:0] q;
    logic signed [39:0] r;
    logic [23:0]        acc;
    data_next = '0;
    for (int k = 0; k < 3; k++) begin
      q = prod[k] + 40'sd8192;
      r = q >>> 14;
      if (r > 40'sd8388607) begin
        acc = 24'h7FFFFF;
      end else if (r < -40'sd8388608) begin
        acc = 24'h800000;
      end else begin
        acc = r[23:0];
      end
      if (st3 == ST_VALID) begin
        data_next[24 * k +: 24]      = acc;
        data_next[72 + 22 * k +: 22] = rate3[k];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rdy_o && v3) begin
      out_data   <= data_next;
      out_status <= st3;
    end
  end

endmodule

// File: design/imu_frame_decode_calibrate_core.sv
// Top level of the IMU frame decoder and calibrator.
// Depends on ifdc_pkg, ifdc_regs, ifdc_capture and ifdc_calib.
//
//   Channel  Direction  Payload
//   s_*      in         tdata: data_byte[7:0]; tuser: frame_start
//   m_*      out        tdata: accel x,y,z (24b each), rate x,y,z (22b each); tuser: status
//   APB      in/out     six registers at byte addresses 0, 8, .. 40, 64-bit data
//
// One byte is taken every cycle while the pipeline can accept a frame. The
// completed frame is registered, then the offset results, the gain products
// and the rounded, saturated result go through their registers in that order;
// the last of these is the result register.
// Reset clears the byte position and the stage valid bits and sets the registers to their defaults.
// A stalled output holds the pipeline only once every stage is full.
module imu_frame_decode_calibrate_core
  import ifdc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] frame_start
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, zero pad
  output logic [1:0]   m_tuser,   // [1:0] frame_status
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  cfg_t   cfg;
  frame_t frame;
  logic   accept;
  logic   frame_done;

  assign accept = s_tvalid && s_tready;

  // Configuration registers.
  ifdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Byte capture and unpacking.
  ifdc_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .frame_start (s_tuser),
    .cfg         (cfg),
    .frame_done  (frame_done),
    .frame       (frame)
  );

  // Calibration pipeline and result register.
  ifdc_calib u_calib (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (frame_done),
    .in_frame   (frame),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_status (m_tuser)
  );

endmodule
